// File: sv/tfc_pkg.sv
package tfc_pkg;

   // Stored texel formats, as held in the format register.
   typedef enum logic [2:0] {
      FMT_ARGB8  = 3'd0,
      FMT_BGRA8  = 3'd1,
      FMT_L8     = 3'd2,
      FMT_A8     = 3'd3,
      FMT_L8A8   = 3'd4,
      FMT_RGBA16F = 3'd5,
      FMT_RGBA32F = 3'd6,
      FMT_R32F   = 3'd7
   } tfc_format_type;

   // Operation codes carried in the request user field.
   localparam logic OP_UNPACK = 1'b0;
   localparam logic OP_PACK   = 1'b1;

   localparam int NumLanes = 4;

   // What one lane is handed.
   typedef struct packed {
      logic [7:0]  unorm;
      logic [15:0] half;
      logic [31:0] word;
   } tfc_lane_in_type;

   // What one lane finds.
   typedef struct packed {
      logic [31:0] unorm_to_float;
      logic [7:0]  float_to_unorm;
      logic [31:0] half_to_float;
      logic [15:0] float_to_half;
   } tfc_lane_out_type;

   // Bytes per texel for each format.
   function automatic logic [4:0] texel_stride(input tfc_format_type fmt);
      logic [4:0] s;
      case (fmt)
         FMT_ARGB8, FMT_BGRA8, FMT_R32F: s = 5'd4;
         FMT_L8, FMT_A8:                 s = 5'd1;
         FMT_L8A8:                       s = 5'd2;
         FMT_RGBA16F:                    s = 5'd8;
         FMT_RGBA32F:                    s = 5'd16;
         default:                        s = 5'd4;
      endcase
      return s;
   endfunction

endpackage

// File: sv/tfc_lane.sv
module tfc_lane
   import tfc_pkg::*;
(
   input  tfc_lane_in_type  lane_in,
   output tfc_lane_out_type lane_out
);

   // Unorm8 to float: byte times the float nearest 1/255, rounded to nearest even.
   logic [31:0] u_prod;
   logic [4:0]  u_msb;
   logic [3:0]  u_sh;
   logic [23:0] u_keep;
   logic [31:0] u_rem;
   logic [31:0] u_halfv;
   logic        u_up;
   logic [24:0] u_mant;
   logic [7:0]  u_exp;

   always_comb begin
      u_prod = 32'(lane_in.unorm) * 32'h0080_8081;
      u_msb  = 5'd23;
      for (int i = 23; i < 32; i++) begin
         if (u_prod[i]) begin
            u_msb = 5'(i);
         end
      end
      u_sh    = 4'(u_msb - 5'd23);
      u_keep  = 24'(u_prod >> u_sh);
      u_rem   = u_prod & ((32'd1 << u_sh) - 32'd1);
      u_halfv = (u_sh == 4'd0) ? 32'd0 : (32'd1 << (u_sh - 4'd1));
      u_up    = (u_sh != 4'd0) &&
                ((u_rem > u_halfv) || ((u_rem == u_halfv) && u_keep[0]));
      u_mant  = {1'b0, u_keep} + 25'(u_up);
      u_exp   = 8'(u_msb) + 8'd96;
      if (u_mant[24]) begin
         u_exp  = u_exp + 8'd1;
         u_mant = u_mant >> 1;
      end
      if (lane_in.unorm == 8'd0) begin
         lane_out.unorm_to_float = 32'd0;
      end else begin
         lane_out.unorm_to_float = {1'b0, u_exp, u_mant[22:0]};
      end
   end

   // Float to unorm8: float product with 255.5, truncated and clamped.
   logic        f_sign;
   logic [7:0]  f_exp;
   logic [22:0] f_frac;
   logic [32:0] f_prod;
   logic [3:0]  f_drop;
   logic [23:0] f_keep;
   logic [32:0] f_rem;
   logic [32:0] f_halfv;
   logic        f_up;
   logic [24:0] f_round;
   logic [33:0] f_val;
   logic [7:0]  f_rsh;
   logic [33:0] f_int;

   always_comb begin
      f_sign  = lane_in.word[31];
      f_exp   = lane_in.word[30:23];
      f_frac  = lane_in.word[22:0];
      f_prod  = 33'({1'b1, f_frac}) * 33'd511;
      f_drop  = f_prod[32] ? 4'd9 : 4'd8;
      f_keep  = 24'(f_prod >> f_drop);
      f_rem   = f_prod & ((33'd1 << f_drop) - 33'd1);
      f_halfv = 33'd1 << (f_drop - 4'd1);
      f_up    = (f_rem > f_halfv) || ((f_rem == f_halfv) && f_keep[0]);
      f_round = {1'b0, f_keep} + 25'(f_up);
      f_val   = 34'(f_round) << f_drop;
      f_rsh   = 8'd151 - f_exp;
      f_int   = (f_rsh >= 8'd34) ? 34'd0 : (f_val >> f_rsh);
      if (f_exp == 8'hff) begin
         lane_out.float_to_unorm = ((f_frac == 23'd0) && !f_sign) ? 8'hff : 8'h00;
      end else if (f_sign || (f_exp == 8'd0)) begin
         lane_out.float_to_unorm = 8'h00;
      end else if (f_exp >= 8'd151) begin
         lane_out.float_to_unorm = 8'hff;
      end else if (f_int >= 34'd255) begin
         lane_out.float_to_unorm = 8'hff;
      end else begin
         lane_out.float_to_unorm = f_int[7:0];
      end
   end

   // Half to float: exact widening, subnormals normalized.
   logic [4:0]  h_exp;
   logic [9:0]  h_frac;
   logic [3:0]  h_msb;
   logic [3:0]  h_sh;
   logic [9:0]  h_norm;

   always_comb begin
      h_exp  = lane_in.half[14:10];
      h_frac = lane_in.half[9:0];
      h_msb  = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h_frac[i]) begin
            h_msb = 4'(i);
         end
      end
      h_sh   = 4'd10 - h_msb;
      h_norm = 10'(h_frac << h_sh);
      if (h_exp == 5'd0) begin
         if (h_frac == 10'd0) begin
            lane_out.half_to_float = {lane_in.half[15], 31'd0};
         end else begin
            lane_out.half_to_float = {lane_in.half[15], 8'd113 - 8'(h_sh), h_norm, 13'd0};
         end
      end else if (h_exp == 5'd31) begin
         lane_out.half_to_float = {lane_in.half[15], 8'hff, h_frac, 13'd0};
      end else begin
         lane_out.half_to_float = {lane_in.half[15], 8'(h_exp) + 8'd112, h_frac, 13'd0};
      end
   end

   // Float to half: round to nearest even, overflow to infinity.
   logic signed [8:0] n_he;
   logic [14:0] n_norm;
   logic [12:0] n_nrem;
   logic        n_nup;
   logic [4:0]  n_sh;
   logic [23:0] n_mm;
   logic [23:0] n_sub;
   logic [23:0] n_srem;
   logic [23:0] n_shalf;
   logic        n_sup;

   always_comb begin
      n_he    = $signed({1'b0, f_exp}) - 9'sd112;
      n_norm  = {n_he[4:0], f_frac[22:13]};
      n_nrem  = f_frac[12:0];
      n_nup   = (n_nrem > 13'h1000) || ((n_nrem == 13'h1000) && n_norm[0]);
      n_sh    = 5'(9'sd14 - n_he);
      n_mm    = {1'b1, f_frac};
      n_sub   = n_mm >> n_sh;
      n_srem  = n_mm & ((24'd1 << n_sh) - 24'd1);
      n_shalf = 24'd1 << (n_sh - 5'd1);
      n_sup   = (n_srem > n_shalf) || ((n_srem == n_shalf) && n_sub[0]);
      if (f_exp == 8'hff) begin
         if (f_frac != 23'd0) begin
            lane_out.float_to_half = {f_sign, 5'h1f, 1'b1, f_frac[21:13]};
         end else begin
            lane_out.float_to_half = {f_sign, 15'h7c00};
         end
      end else if (n_he >= 9'sd31) begin
         lane_out.float_to_half = {f_sign, 15'h7c00};
      end else if (n_he >= 9'sd1) begin
         lane_out.float_to_half = {f_sign, n_norm + 15'(n_nup)};
      end else if (n_he < -9'sd10) begin
         lane_out.float_to_half = {f_sign, 15'd0};
      end else begin
         lane_out.float_to_half = {f_sign, n_sub[14:0] + 15'(n_sup)};
      end
   end

endmodule

// File: sv/tfc_merge.sv
module tfc_merge
   import tfc_pkg::*;
(
   input  logic             op,
   input  tfc_format_type   fmt,
   input  logic [31:0]      word0,
   input  logic [31:0]      word1,
   input  logic [31:0]      word2,
   input  logic [31:0]      word3,
   input  tfc_lane_out_type lane0,
   input  tfc_lane_out_type lane1,
   input  tfc_lane_out_type lane2,
   input  tfc_lane_out_type lane3,
   output logic [127:0]     words
);

   // Assemble the four result words from what the lanes found.
   always_comb begin
      words = '0;
      if (op == OP_UNPACK) begin
         case (fmt)
            FMT_RGBA16F: words = {lane3.half_to_float, lane2.half_to_float,
                                  lane1.half_to_float, lane0.half_to_float};
            FMT_RGBA32F: words = {word3, word2, word1, word0};
            FMT_R32F:    words = {word0, word0, word0, word0};
            default:     words = {lane3.unorm_to_float, lane2.unorm_to_float,
                                  lane1.unorm_to_float, lane0.unorm_to_float};
         endcase
      end else begin
         case (fmt)
            FMT_ARGB8:   words[31:0] = {lane2.float_to_unorm, lane1.float_to_unorm,
                                        lane0.float_to_unorm, lane3.float_to_unorm};
            FMT_BGRA8:   words[31:0] = {lane3.float_to_unorm, lane0.float_to_unorm,
                                        lane1.float_to_unorm, lane2.float_to_unorm};
            FMT_L8:      words[7:0] = lane0.float_to_unorm;
            FMT_A8:      words[7:0] = lane3.float_to_unorm;
            FMT_L8A8:    words[15:0] = {lane3.float_to_unorm, lane0.float_to_unorm};
            FMT_RGBA16F: words[63:0] = {lane3.float_to_half, lane2.float_to_half,
                                        lane1.float_to_half, lane0.float_to_half};
            FMT_RGBA32F: words = {word3, word2, word1, word0};
            default:     words[31:0] = word0;
         endcase
      end
   end

endmodule

// File: sv/texel_format_converter.sv
// Texel format converter: one texel between a stored format and RGBA float32.
// The result of an input transfer is registered straight into the output register.
// Throughput: one texel per cycle unless the result side holds back; four lanes convert all channels at once.
// The output register accepts a new texel while its result is being taken.
// Reset (synchronous, active high) empties the output register and sets ARGB8.
module texel_format_converter
   import tfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [2:0]   csr_wdata,       // texel_format
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,       // in_word0, in_word1, in_word2, in_word3
   input  logic         req_tuser,       // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata        // out_word0..out_word3, texel_bytes, zero pad
);

   tfc_format_type   format_ff, format_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [135:0]     rsp_data_ff, rsp_data_in;
   logic [31:0]      word [NumLanes];
   tfc_lane_in_type  lane_in [NumLanes];
   tfc_lane_out_type lane_out [NumLanes];
   logic [127:0]     merged;
   logic [7:0]       tex_byte [4];

   // Split the request words.
   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         word[i] = req_tdata[32*i +: 32];
      end
      for (int i = 0; i < 4; i++) begin
         tex_byte[i] = word[0][8*i +: 8];
      end
   end

   // Route each channel to its lane by format.
   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         lane_in[i].word = word[i];
         lane_in[i].unorm = tex_byte[0];
      end
      lane_in[0].half = word[0][15:0];
      lane_in[1].half = word[0][31:16];
      lane_in[2].half = word[1][15:0];
      lane_in[3].half = word[1][31:16];
      case (format_ff)
         FMT_ARGB8: begin
            lane_in[0].unorm = tex_byte[1];
            lane_in[1].unorm = tex_byte[2];
            lane_in[2].unorm = tex_byte[3];
            lane_in[3].unorm = tex_byte[0];
         end
         FMT_BGRA8: begin
            lane_in[0].unorm = tex_byte[2];
            lane_in[1].unorm = tex_byte[1];
            lane_in[2].unorm = tex_byte[0];
            lane_in[3].unorm = tex_byte[3];
         end
         FMT_L8A8: begin
            lane_in[3].unorm = tex_byte[1];
         end
         default: begin
         end
      endcase
   end

   for (genvar g = 0; g < NumLanes; g++) begin : g_lane
      tfc_lane u_lane (
         .lane_in  (lane_in[g]),
         .lane_out (lane_out[g])
      );
   end

   tfc_merge u_merge (
      .op    (req_tuser),
      .fmt   (format_ff),
      .word0 (word[0]),
      .word1 (word[1]),
      .word2 (word[2]),
      .word3 (word[3]),
      .lane0 (lane_out[0]),
      .lane1 (lane_out[1]),
      .lane2 (lane_out[2]),
      .lane3 (lane_out[3]),
      .words (merged)
   );

   // Output register handshake.
   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      format_in    = csr_we ? tfc_format_type'(csr_wdata) : format_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_tvalid && req_tready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'd0, texel_stride(format_ff), merged};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff    <= FMT_ARGB8;
         rsp_valid_ff <= 1'b0;
      end else begin
         format_ff    <= format_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks.
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output register not empty after reset");
   a_transfer_lands : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("accepted texel did not reach the output register");
   a_stride_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[132:128] == 5'd1 || rsp_tdata[132:128] == 5'd2 ||
                      rsp_tdata[132:128] == 5'd4 || rsp_tdata[132:128] == 5'd8 ||
                      rsp_tdata[132:128] == 5'd16))
      else $error("bad texel byte count");

endmodule

// File: tb/texel_format_converter_test.sv
module texel_format_converter_test
   import tfc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One converted texel: four result words and the texel size.
   typedef struct {
      logic [31:0] word [NumLanes];
      logic [4:0]  nbytes;
   } texel_result_type;

   // One line of the directed stimulus.
   typedef struct {
      tfc_format_type   fmt;
      logic             op;
      logic [31:0]      word [NumLanes];
      bit               typed;
      texel_result_type want;
   } texel_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // in_word0, in_word1, in_word2, in_word3
   logic         req_tuser = 1'b0; // op
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;        // out_word0..out_word3, texel_bytes, zero pad

   texel_result_type pending_texels [$];
   texel_row_type    directed_rows [$];
   tfc_format_type   active_fmt = FMT_ARGB8;
   bit               no_stall = 1'b0;
   int               error_count = 0;
   int               cycle_count = 0;

   texel_format_converter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 50 MHz clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Round a positive value q * 2^ex to 24 significant bits, nearest even.
   function automatic void round_to_24(inout longint unsigned q, inout int ex);
      int msb;
      int sh;
      longint unsigned keep;
      longint unsigned rem;
      longint unsigned halfway;
      msb = 0;
      for (int i = 0; i < 64; i++) if (q[i]) msb = i;
      if (msb > 23) begin
         sh = msb - 23;
         keep = q >> sh;
         rem = q & ((64'd1 << sh) - 64'd1);
         halfway = 64'd1 << (sh - 1);
         if (rem > halfway || (rem == halfway && keep[0])) keep++;
         if (keep == (64'd1 << 24)) begin
            keep = keep >> 1;
            sh++;
         end
         q = keep;
         ex += sh;
      end
   endfunction

   // Byte times the single-precision constant 1/255, rounded as a float multiply.
   function automatic logic [31:0] unorm_to_single(logic [7:0] v);
      longint unsigned q;
      int ex;
      logic [7:0] bexp;
      if (v == 8'd0) return 32'd0;
      q = longint'(v) * 64'h808081;
      ex = -31;
      round_to_24(q, ex);
      bexp = 8'(ex + 23 + 127);
      return {1'b0, bexp, q[22:0]};
   endfunction

   // Float times 255.5 (single rounding), truncated and clamped to a byte.
   function automatic logic [7:0] single_to_unorm(logic [31:0] x);
      longint unsigned q;
      int ex;
      longint unsigned iv;
      if (x[30:23] == 8'hff) return (x[22:0] == 0 && !x[31]) ? 8'hff : 8'h00;
      if (x[31] || x[30:0] == 0) return 8'h00;
      q = (x[30:23] != 0) ? {41'd1, x[22:0]} : {41'd0, x[22:0]};
      ex = ((x[30:23] != 0) ? int'(x[30:23]) : 1) - 151;
      q = q * 64'd511;
      round_to_24(q, ex);
      if (ex >= 0) return 8'hff;
      if (-ex > 63) return 8'h00;
      iv = q >> (-ex);
      return (iv >= 64'd255) ? 8'hff : iv[7:0];
   endfunction

   // Half to single, exact, payload kept.
   function automatic logic [31:0] half_to_single(logic [15:0] h);
      logic [31:0] sgn;
      logic [10:0] man;
      int ex;
      sgn = {h[15], 31'd0};
      man = {1'b0, h[9:0]};
      if (h[14:10] == 5'd0) begin
         if (man == 0) return sgn;
         ex = 113;
         while (!man[10]) begin
            man = man << 1;
            ex--;
         end
         return sgn | (32'(ex) << 23) | (32'(man[9:0]) << 13);
      end
      if (h[14:10] == 5'd31) return sgn | 32'h7f800000 | (32'(h[9:0]) << 13);
      return sgn | (32'(h[14:10] + 112) << 23) | (32'(h[9:0]) << 13);
   endfunction

   // Single to half with nearest-even rounding, overflow to infinity.
   function automatic logic [15:0] single_to_half(logic [31:0] x);
      logic [15:0] sgn;
      int he;
      int sh;
      logic [31:0] h;
      logic [31:0] rem;
      logic [31:0] mm;
      logic [31:0] halfway;
      sgn = {x[31], 15'd0};
      he = int'(x[30:23]) - 112;
      if (x[30:23] == 8'hff)
         return (x[22:0] != 0) ? (sgn | 16'h7e00 | 16'(x[22:13])) : (sgn | 16'h7c00);
      if (he >= 31) return sgn | 16'h7c00;
      if (he >= 1) begin
         h = (32'(he) << 10) | 32'(x[22:13]);
         rem = 32'(x[12:0]);
         if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
         return sgn | h[15:0];
      end
      if (he < -10) return sgn;
      sh = 14 - he;
      mm = {8'd0, 1'b1, x[22:0]};
      h = mm >> sh;
      rem = mm & ((32'd1 << sh) - 32'd1);
      halfway = 32'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && h[0])) h++;
      return sgn | h[15:0];
   endfunction

   // Expected conversion of one texel under the given format.
   function automatic texel_result_type convert_texel(tfc_format_type fmt, logic op,
                                                      logic [31:0] w [NumLanes]);
      texel_result_type r;
      logic [31:0] ch;
      for (int i = 0; i < NumLanes; i++) r.word[i] = '0;
      case (fmt)
         FMT_ARGB8, FMT_BGRA8, FMT_R32F: r.nbytes = 5'd4;
         FMT_L8, FMT_A8:                 r.nbytes = 5'd1;
         FMT_L8A8:                       r.nbytes = 5'd2;
         FMT_RGBA16F:                    r.nbytes = 5'd8;
         default:                        r.nbytes = 5'd16;
      endcase
      if (op == OP_UNPACK) begin
         case (fmt)
            FMT_ARGB8: begin
               r.word[0] = unorm_to_single(w[0][15:8]);
               r.word[1] = unorm_to_single(w[0][23:16]);
               r.word[2] = unorm_to_single(w[0][31:24]);
               r.word[3] = unorm_to_single(w[0][7:0]);
            end
            FMT_BGRA8: begin
               r.word[0] = unorm_to_single(w[0][23:16]);
               r.word[1] = unorm_to_single(w[0][15:8]);
               r.word[2] = unorm_to_single(w[0][7:0]);
               r.word[3] = unorm_to_single(w[0][31:24]);
            end
            FMT_L8, FMT_A8: begin
               ch = unorm_to_single(w[0][7:0]);
               for (int i = 0; i < NumLanes; i++) r.word[i] = ch;
            end
            FMT_L8A8: begin
               ch = unorm_to_single(w[0][7:0]);
               for (int i = 0; i < 3; i++) r.word[i] = ch;
               r.word[3] = unorm_to_single(w[0][15:8]);
            end
            FMT_RGBA16F: begin
               r.word[0] = half_to_single(w[0][15:0]);
               r.word[1] = half_to_single(w[0][31:16]);
               r.word[2] = half_to_single(w[1][15:0]);
               r.word[3] = half_to_single(w[1][31:16]);
            end
            FMT_RGBA32F: for (int i = 0; i < NumLanes; i++) r.word[i] = w[i];
            default:     for (int i = 0; i < NumLanes; i++) r.word[i] = w[0];
         endcase
      end else begin
         case (fmt)
            FMT_ARGB8: r.word[0] = {single_to_unorm(w[2]), single_to_unorm(w[1]),
                                    single_to_unorm(w[0]), single_to_unorm(w[3])};
            FMT_BGRA8: r.word[0] = {single_to_unorm(w[3]), single_to_unorm(w[0]),
                                    single_to_unorm(w[1]), single_to_unorm(w[2])};
            FMT_L8:    r.word[0] = {24'd0, single_to_unorm(w[0])};
            FMT_A8:    r.word[0] = {24'd0, single_to_unorm(w[3])};
            FMT_L8A8:  r.word[0] = {16'd0, single_to_unorm(w[3]), single_to_unorm(w[0])};
            FMT_RGBA16F: begin
               r.word[0] = {single_to_half(w[1]), single_to_half(w[0])};
               r.word[1] = {single_to_half(w[3]), single_to_half(w[2])};
            end
            FMT_RGBA32F: for (int i = 0; i < NumLanes; i++) r.word[i] = w[i];
            default:     r.word[0] = w[0];
         endcase
      end
      return r;
   endfunction

   // Result side: random back-pressure except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= no_stall || ($urandom_range(99) >= 33);
   end

   // Compare each result transfer with the oldest expected texel.
   always @(posedge clock) begin
      texel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_texels.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_texels.pop_front();
            for (int i = 0; i < NumLanes; i++) begin
               if (rsp_tdata[32*i +: 32] !== want.word[i]) begin
                  $display("%0t: out_word%0d expected %h actual %h", $time, i,
                           want.word[i], rsp_tdata[32*i +: 32]);
                  error_count++;
               end
            end
            if (rsp_tdata[132:128] !== want.nbytes) begin
               $display("%0t: texel_bytes expected %0d actual %0d", $time,
                        want.nbytes, rsp_tdata[132:128]);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 300000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stop sending and wait until every expected texel has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_texels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Change the stored format while the converter is idle.
   task automatic set_format(tfc_format_type fmt);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= fmt;
      @(posedge clock);
      csr_we <= 1'b0;
      active_fmt = fmt;
   endtask

   // Send one texel; a typed result overrides the prediction.
   task automatic send_texel(logic op, logic [31:0] w [NumLanes], bit typed,
                             texel_result_type want);
      if (!no_stall && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {w[3], w[2], w[1], w[0]};
      do @(posedge clock); while (!req_tready);
      pending_texels.push_back(typed ? want : convert_texel(active_fmt, op, w));
   endtask

   task automatic add_row(tfc_format_type fmt, logic op, logic [31:0] w0, logic [31:0] w1,
                          logic [31:0] w2, logic [31:0] w3, bit typed,
                          logic [31:0] e0, logic [31:0] e1, logic [31:0] e2,
                          logic [31:0] e3, logic [4:0] nb);
      texel_row_type row;
      row.fmt = fmt;
      row.op = op;
      row.word = '{w0, w1, w2, w3};
      row.typed = typed;
      row.want.word = '{e0, e1, e2, e3};
      row.want.nbytes = nb;
      directed_rows.push_back(row);
   endtask

   // Random float biased toward the interesting ranges of the converter.
   function automatic logic [31:0] random_float();
      case ($urandom_range(5))
         0: return $urandom();
         1: return {1'b0, 8'($urandom_range(127, 118)), 23'($urandom())};
         2: return {1'($urandom()), 8'($urandom_range(150, 95)), 23'($urandom())};
         3: return {1'b0, 8'd134, 23'($urandom())};
         4: begin
            case ($urandom_range(5))
               0: return 32'h7f800000;
               1: return 32'hff800000;
               2: return {1'($urandom()), 8'hff, 23'($urandom())};
               3: return {1'($urandom()), 31'd0};
               4: return {1'($urandom()), 8'd0, 23'($urandom())};
               default: return 32'h3f800000;
            endcase
         end
         default: return {1'b0, 8'($urandom_range(126, 119)), 23'($urandom_range(7))};
      endcase
   endfunction

   initial begin
      logic [31:0] w [NumLanes];
      texel_result_type none;
      tfc_format_type fmt;
      int count;
      int sent;

      none.word = '{default: '0};
      none.nbytes = '0;

      // Directed rows; the first ones run on the format set by reset.
      add_row(FMT_ARGB8, OP_UNPACK, 0, 0, 0, 0, 1, 0, 0, 0, 0, 4);
      add_row(FMT_ARGB8, OP_UNPACK, 32'hffffffff, '1, '1, '1, 1,
              32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000, 4);
      add_row(FMT_ARGB8, OP_PACK, 32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000,
              1, 32'hffffffff, 0, 0, 0, 4);
      add_row(FMT_ARGB8, OP_PACK, 32'h7fc00000, 32'hbf800000, 32'h7f800000, 0,
              1, 32'hff000000, 0, 0, 0, 4);
      add_row(FMT_ARGB8, OP_UNPACK, 32'h80ff017f, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(FMT_BGRA8, OP_UNPACK, 32'h12ab34cd, '1, '1, '1, 0, 0, 0, 0, 0, 0);
      add_row(FMT_BGRA8, OP_PACK, 32'h3f000000, 32'h3e800000, 32'h7f7fffff, 32'h00000001,
              0, 0, 0, 0, 0, 0);
      add_row(FMT_L8, OP_UNPACK, 32'h123456ff, '1, '1, '1, 1,
              32'h3f800000, 32'h3f800000, 32'h3f800000, 32'h3f800000, 1);
      add_row(FMT_L8, OP_PACK, 32'h3f800000, '1, '1, '1, 1, 32'h000000ff, 0, 0, 0, 1);
      add_row(FMT_A8, OP_PACK, 0, '1, '1, 32'h3f800000, 1, 32'h000000ff, 0, 0, 0, 1);
      add_row(FMT_A8, OP_UNPACK, 32'hffffff80, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(FMT_L8A8, OP_UNPACK, 32'h0000ff00, 0, 0, 0, 1,
              0, 0, 0, 32'h3f800000, 2);
      add_row(FMT_L8A8, OP_PACK, 32'h3f800000, 32'h3f800000, 32'h3f800000, 0,
              1, 32'h000000ff, 0, 0, 0, 2);
      add_row(FMT_RGBA16F, OP_PACK, 32'h3f800000, 32'h3f800000, 32'h3f800000,
              32'h3f800000, 1, 32'h3c003c00, 32'h3c003c00, 0, 0, 8);
      add_row(FMT_RGBA16F, OP_UNPACK, 32'h3c007c01, 32'h8001fbff, '1, '1, 0,
              0, 0, 0, 0, 0);
      add_row(FMT_RGBA16F, OP_PACK, 32'h477ff000, 32'h322bcc77, 32'h33000001,
              32'hffc12345, 0, 0, 0, 0, 0, 0);
      add_row(FMT_RGBA16F, OP_PACK, 32'h387fe000, 32'h80000000, 32'h33800000,
              32'h477fefff, 0, 0, 0, 0, 0, 0);
      add_row(FMT_RGBA32F, OP_UNPACK, 32'h7fa00001, 32'hffffffff, 0, 32'h80000000, 1,
              32'h7fa00001, 32'hffffffff, 0, 32'h80000000, 16);
      add_row(FMT_RGBA32F, OP_PACK, 32'hff812345, 1, 32'h7f800000, 32'h3f800000, 1,
              32'hff812345, 1, 32'h7f800000, 32'h3f800000, 16);
      add_row(FMT_R32F, OP_UNPACK, 32'h7fa00001, '1, '1, '1, 1,
              32'h7fa00001, 32'h7fa00001, 32'h7fa00001, 32'h7fa00001, 4);
      add_row(FMT_R32F, OP_PACK, 32'hdeadbeef, '1, '1, '1, 1, 32'hdeadbeef, 0, 0, 0, 4);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].fmt != active_fmt) set_format(directed_rows[i].fmt);
         send_texel(directed_rows[i].op, directed_rows[i].word, directed_rows[i].typed,
                    directed_rows[i].want);
      end

      // Random phases, each on one format; every format comes up at least once.
      sent = 0;
      for (int phase = 0; sent < 1900; phase++) begin
         fmt = (phase < 8) ? tfc_format_type'(7 - phase) : tfc_format_type'($urandom_range(7));
         set_format(fmt);
         no_stall = (phase == 4);
         count = $urandom_range(160, 80);
         for (int k = 0; k < count; k++) begin
            for (int i = 0; i < NumLanes; i++) w[i] = $urandom_range(1) ? random_float()
                                                                      : $urandom();
            send_texel(1'($urandom()), w, 0, none);
            sent++;
            // Let the pipeline run empty once in the middle of a phase.
            if (phase == 2 && k == count / 2) drain_results();
         end
         no_stall = 1'b0;
      end

      drain_results();
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
